// ===== hdl/crs_pkg.sv =====
// Package for the coprime stride block sampler: codes, states and fixed widths.
package crs_pkg;

	// Default values for the top-level parameters.
	localparam int BLOCK_BITS_DEF = 32;
	localparam int MAX_TUPLES_DEF = 2048;

	// Fixed field widths.
	localparam int DATA_W    = 32;
	localparam int OFF_W     = 12;
	localparam int LIM_W     = 16;
	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 32;
	localparam int REQ_W     = 3;
	localparam int PADDR_W   = 3;

	// Register map, word index taken from paddr[2].
	localparam logic REG_TIME_LIMIT = 1'b0;
	localparam logic [DATA_W-1:0] TIME_LIMIT_RST = 32'd1000;

	// Request kinds.
	localparam logic [REQ_W-1:0] REQ_SETUP = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BEGIN = 3'd1;
	localparam logic [REQ_W-1:0] REQ_NEXT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TUPLE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TICK  = 3'd4;

	typedef enum logic [2:0] {
		STAT_OK,
		STAT_ALL_DONE,
		STAT_TIME_UP,
		STAT_EMPTY,
		STAT_REJECT,
		STAT_BLOCK_END,
		STAT_NOT_READY
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_DIV_STEP,
		FSM_DIV_START,
		FSM_GCD,
		FSM_WALK,
		FSM_PUSH
	} fsm_t;

endpackage

// ===== hdl/crs_rem.sv =====
// Shared restoring remainder unit, one quotient bit per cycle.
module crs_rem import crs_pkg::*; #(
	parameter int W = BLOCK_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,   // never zero when started
	output logic         done,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (cnt_q != '0)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			// trial stays below twice the divisor
			rem_q <= (trial >= {1'b0, dsr_q}) ? diff[W-1:0] : trial[W-1:0];
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/coprime_stride_block_sampler.sv =====
// Top level of the coprime stride block sampler: handshakes, sequencer and sampler state.
//
//  channel  | dir | handshake              | contents
//  ---------+-----+------------------------+---------------------------------------------
//  s_*      | in  | tvalid/tready          | tuser: req_type; tdata: rel_blocks,
//           |     |                        |   first_block_draw, step_candidate, max_offset
//  m_*      | out | tvalid/tready          | tuser: status; tdata: result_value
//  APB      | in  | psel/penable, pready=1 | reg 0 (byte 0): time_limit
//
//  Begin, tuple, tick and refused requests pass through EXEC and PUSH before m_tvalid
//  rises; the next word can be taken once the sequencer is back in IDLE.
//  Next block walks candidate blocks in WALK (at least one, more when blocks at or
//  above the current size are skipped), bounded by the block count.
//  Setup with more than one block runs the shared remainder unit: two remainders for the
//  step and start block, then one per Euclid step.
//  One word in flight at a time; s_tready is high only while the sequencer is idle.
//  A result waits in the output register while m_tready is low; the next word is still
//  taken, and its result is held back until the output register frees up.
//  Reset clears all sampler state; time_limit resets to 1000.
module coprime_stride_block_sampler import crs_pkg::*; #(
	parameter int BLOCK_BITS = BLOCK_BITS_DEF,
	parameter int MAX_TUPLES = MAX_TUPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [31:0] rel_blocks, [63:32] first_block_draw, [95:64] step_candidate,
	// [107:96] max_offset, [111:108] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [2:0] req_type
	input  logic [REQ_W-1:0]     s_tuser,
	// master side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] result_value
	output logic [M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [2:0]           m_tuser,
	// config port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,   // byte offset bits ignored
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	localparam int BB = BLOCK_BITS;

	// config
	logic [DATA_W-1:0] tlim_q;

	// latched request
	logic [REQ_W-1:0] req_q;
	logic [BB-1:0]    rel_q, draw_q, cand_q;
	logic [OFF_W-1:0] maxo_q;
	logic [BB-1:0]    draw_d;

	// sampler state
	logic [BB-1:0]     blk_cnt_q, start_q, stride_q, last_blk_q;
	logic [DATA_W-1:0] bd_q, et_q;
	logic [OFF_W-1:0]  lo_q;
	logic [BB-1:0]     blk_cnt_d, start_d, stride_d, last_blk_d;
	logic [DATA_W-1:0] bd_d, et_d;
	logic [OFF_W-1:0]  lo_d;

	// setup / walk scratch
	logic [BB-1:0] gx_q, step_q, guard_q;
	logic [BB-1:0] gx_d, step_d, guard_d;

	// pending result and output register
	status_t           res_st_q, res_st_d;
	logic [DATA_W-1:0] res_val_q, res_val_d;
	logic              ov_q, ov_d;
	status_t           ost_q;
	logic [M_TDATA_W-1:0] oval_q;

	fsm_t state_q, state_d;

	// remainder unit
	logic          div_start;
	logic [BB-1:0] div_a, div_d;
	logic          div_done;
	logic [BB-1:0] div_rem;

	// walk / tuple helpers
	logic [BB:0]        wsum;
	logic [BB-1:0]      wnext, gnext;
	logic [DATA_W-1:0]  bd_inc;
	logic [LIM_W-1:0]   lim, toff;
	logic [OFF_W:0]     toff13;
	logic               in_acc, cfg_wr, out_free;

	assign in_acc   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !ov_q || m_tready;

	crs_rem #(.W(BB)) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_d),
		.done      (div_done),
		.remainder (div_rem)
	);

	// next block: b + stride stays below twice the count
	assign wsum  = {1'b0, last_blk_q} + {1'b0, stride_q};
	assign wnext = (wsum >= {1'b0, blk_cnt_q}) ? BB'(wsum - {1'b0, blk_cnt_q}) : wsum[BB-1:0];
	assign gnext = guard_q - BB'(1);

	// tuple offset, limit clamped to MAX_TUPLES
	assign lim    = (LIM_W'(maxo_q) > LIM_W'(MAX_TUPLES)) ? LIM_W'(MAX_TUPLES) : LIM_W'(maxo_q);
	assign toff13 = (lo_q == '0) ? (OFF_W+1)'(1) : {1'b0, lo_q} + (OFF_W+1)'(1);
	assign toff   = LIM_W'(toff13);

	assign bd_inc = (bd_q == '1) ? bd_q : bd_q + DATA_W'(1);

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		div_start  = 1'b0;
		div_a      = rel_q;
		div_d      = rel_q;
		draw_d     = draw_q;
		blk_cnt_d  = blk_cnt_q;
		start_d    = start_q;
		stride_d   = stride_q;
		last_blk_d = last_blk_q;
		bd_d       = bd_q;
		et_d       = et_q;
		lo_d       = lo_q;
		gx_d       = gx_q;
		step_d     = step_q;
		guard_d    = guard_q;
		res_st_d   = res_st_q;
		res_val_d  = res_val_q;
		ov_d       = m_tready ? 1'b0 : ov_q;

		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = FSM_EXEC;
			end
			FSM_EXEC: begin
				res_st_d  = STAT_OK;
				res_val_d = '0;
				state_d   = FSM_PUSH;
				case (req_q)
					REQ_SETUP: begin
						if (rel_q == '0) begin
							res_st_d = STAT_EMPTY;
						end else if (rel_q == BB'(1)) begin
							// single block: step 1, start 0
							blk_cnt_d = rel_q;
							start_d   = '0;
							stride_d  = BB'(1);
							bd_d      = '0;
							lo_d      = '0;
							res_val_d = DATA_W'(1);
						end else begin
							div_start = 1'b1;
							div_a     = cand_q;
							div_d     = rel_q;
							state_d   = FSM_DIV_STEP;
						end
					end
					REQ_BEGIN: begin
						bd_d = '0;
						lo_d = '0;
					end
					REQ_NEXT: begin
						if (stride_q == '0 || blk_cnt_q == '0) begin
							res_st_d = STAT_NOT_READY;
						end else begin
							// first request of a scan reloads the walk
							if (bd_q == '0) begin
								last_blk_d = start_q;
								et_d       = '0;
							end
							bd_d = bd_inc;
							if (bd_inc > DATA_W'(blk_cnt_q))
								res_st_d = STAT_ALL_DONE;
							else if (((bd_q == '0) ? '0 : et_q) >= tlim_q)
								res_st_d = STAT_TIME_UP;
							else if (rel_q == '0)
								res_st_d = STAT_EMPTY;
							else begin
								guard_d = blk_cnt_q;
								state_d = FSM_WALK;
							end
						end
					end
					REQ_TUPLE: begin
						if (toff > lim) begin
							lo_d     = '0;
							res_st_d = STAT_BLOCK_END;
						end else begin
							lo_d      = toff[OFF_W-1:0];
							res_val_d = DATA_W'(toff);
						end
					end
					REQ_TICK: begin
						if (et_q != '1)
							et_d = et_q + DATA_W'(1);
					end
					default: begin
					end
				endcase
			end
			FSM_DIV_STEP: begin
				if (div_done) begin
					step_d    = div_rem;
					div_start = 1'b1;
					div_a     = draw_q;
					div_d     = rel_q;
					state_d   = FSM_DIV_START;
				end
			end
			FSM_DIV_START: begin
				if (div_done) begin
					draw_d = div_rem;
					if (step_q == '0) begin
						res_st_d = STAT_REJECT;
						state_d  = FSM_PUSH;
					end else begin
						// Euclid: x = step, y = count, then x <- y mod x
						gx_d      = step_q;
						div_start = 1'b1;
						div_a     = rel_q;
						div_d     = step_q;
						state_d   = FSM_GCD;
					end
				end
			end
			FSM_GCD: begin
				if (div_done) begin
					if (div_rem == '0) begin
						state_d = FSM_PUSH;
						if (gx_q == BB'(1)) begin
							blk_cnt_d = rel_q;
							start_d   = draw_q;
							stride_d  = step_q;
							bd_d      = '0;
							lo_d      = '0;
							res_val_d = DATA_W'(step_q);
						end else begin
							res_st_d = STAT_REJECT;
						end
					end else begin
						gx_d      = div_rem;
						div_start = 1'b1;
						div_a     = gx_q;
						div_d     = div_rem;
					end
				end
			end
			FSM_WALK: begin
				last_blk_d = wnext;
				guard_d    = gnext;
				if (!(wnext >= rel_q && gnext != '0)) begin
					res_val_d = DATA_W'(wnext);
					state_d   = FSM_PUSH;
				end
			end
			FSM_PUSH: begin
				if (out_free) begin
					ov_d    = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			tlim_q     <= TIME_LIMIT_RST;
			blk_cnt_q  <= '0;
			start_q    <= '0;
			stride_q   <= '0;
			last_blk_q <= '0;
			bd_q       <= '0;
			et_q       <= '0;
			lo_q       <= '0;
			ov_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			if (cfg_wr && paddr[2] == REG_TIME_LIMIT)
				tlim_q <= pwdata;
			blk_cnt_q  <= blk_cnt_d;
			start_q    <= start_d;
			stride_q   <= stride_d;
			last_blk_q <= last_blk_d;
			bd_q       <= bd_d;
			et_q       <= et_d;
			lo_q       <= lo_d;
			ov_q       <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= s_tuser;
			rel_q  <= s_tdata[BB-1:0];
			draw_q <= s_tdata[32 +: BB];
			cand_q <= s_tdata[64 +: BB];
			maxo_q <= s_tdata[96 +: OFF_W];
		end else begin
			draw_q <= draw_d;
		end
		gx_q      <= gx_d;
		step_q    <= step_d;
		guard_q   <= guard_d;
		res_st_q  <= res_st_d;
		res_val_q <= res_val_d;
		if (state_q == FSM_PUSH && out_free) begin
			ost_q  <= res_st_q;
			oval_q <= M_TDATA_W'(res_val_q);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = oval_q;
	assign m_tuser  = ost_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_TIME_LIMIT) ? tlim_q : '0;

endmodule

// ===== hdl/crs_chk.sv =====
// Port-level checker for the coprime stride block sampler, bound to the top level.
module crs_chk import crs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [REQ_W-1:0]     s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [2:0]           m_tuser,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [PADDR_W-1:0]   paddr,
	input logic [DATA_W-1:0]    pwdata,
	input logic [DATA_W-1:0]    prdata,
	input logic                 pready
);

	logic wr_tl;
	assign wr_tl = psel && penable && pwrite && pready && (paddr[2] == REG_TIME_LIMIT);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// every status other than ok carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> m_tdata == '0)
		else $error("nonzero value with error status");

	// one word at a time: input closes right after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while busy");

	// time_limit reads back what was written
	a_cfg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		$past(wr_tl) && (paddr[2] == REG_TIME_LIMIT) |-> prdata == $past(pwdata))
		else $error("time_limit readback mismatch");

endmodule

bind coprime_stride_block_sampler crs_chk u_crs_chk (.*);

// ===== dv/stride_walk_checker.sv =====
// Checker for the coprime stride block sampler: tracks sampler state, predicts and compares words.
`timescale 1ns / 100ps

module stride_walk_checker import crs_pkg::*; #(
	parameter int BLOCK_BITS = BLOCK_BITS_DEF,
	parameter int MAX_TUPLES = MAX_TUPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [REQ_W-1:0]     s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic [2:0]           m_tuser,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]    pwdata,
	input  logic                 pready,
	output int                   mismatches,
	output int                   awaiting
);

	localparam logic [DATA_W-1:0] BMASK = 32'hFFFF_FFFF >> (32 - BLOCK_BITS);

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   value;
	} sampler_answer_t;

	// sampler state copy
	logic [DATA_W-1:0] tick_budget;
	logic [DATA_W-1:0] blk_count;
	logic [DATA_W-1:0] blk_start;
	logic [DATA_W-1:0] stride_q;
	logic [DATA_W-1:0] blk_last;
	logic [DATA_W-1:0] visited;
	logic [DATA_W-1:0] ticks;
	logic [DATA_W-1:0] offset_q;

	sampler_answer_t expected_answers[$];
	sampler_answer_t want;
	sampler_answer_t got;
	int              words_seen;

	task automatic log_mismatch(input string what, input logic [DATA_W-1:0] seen,
		input logic [DATA_W-1:0] wanted);
		$display("MISMATCH word %0d %s: got 0x%0h, want 0x%0h (t=%0t)",
			words_seen, what, seen, wanted, $time);
		mismatches++;
	endtask

	task automatic advance_sampler(input logic [REQ_W-1:0] kind,
		input logic [S_TDATA_W-1:0] data, output sampler_answer_t ans);
		logic [DATA_W-1:0] rel, draw, cand, s, x, y, t, b, guard;
		logic [63:0]       sum;
		logic [OFF_W-1:0]  maxo;
		logic [DATA_W-1:0] lim, nxt;
		bit                ok;
		rel  = data[31:0] & BMASK;
		draw = data[63:32] & BMASK;
		cand = data[95:64] & BMASK;
		maxo = data[107:96];
		ans.status = STAT_OK;
		ans.value  = '0;
		case (kind)
			REQ_SETUP: begin
				if (rel == 0) begin
					ans.status = STAT_EMPTY;
				end else begin
					ok = 1'b1;
					if (rel == 1) begin
						s = 1;
					end else begin
						s = cand % rel;
						x = s;
						y = rel;
						while (x != 0) begin
							t = x;
							x = y % x;
							y = t;
						end
						if (s == 0 || y > 1)
							ok = 1'b0;
					end
					if (ok) begin
						blk_count = rel;
						blk_start = draw % rel;
						stride_q  = s;
						visited   = '0;
						offset_q  = '0;
						ans.value = s;
					end else begin
						ans.status = STAT_REJECT;
					end
				end
			end
			REQ_BEGIN: begin
				visited  = '0;
				offset_q = '0;
			end
			REQ_NEXT: begin
				if (stride_q == 0 || blk_count == 0) begin
					ans.status = STAT_NOT_READY;
				end else begin
					if (visited == 0) begin
						blk_last = blk_start;
						ticks    = '0;
					end
					if (visited != '1)
						visited++;
					if (visited > blk_count) begin
						ans.status = STAT_ALL_DONE;
					end else if (ticks >= tick_budget) begin
						ans.status = STAT_TIME_UP;
					end else if (rel == 0) begin
						ans.status = STAT_EMPTY;
					end else begin
						// skip blocks beyond the shrunk size, at most one lap
						b     = blk_last;
						guard = blk_count;
						do begin
							sum = {32'd0, b} + {32'd0, stride_q};
							b   = 32'(sum % {32'd0, blk_count});
							guard--;
						end while (b >= rel && guard != 0);
						blk_last  = b;
						ans.value = b;
					end
				end
			end
			REQ_TUPLE: begin
				lim = (maxo > MAX_TUPLES) ? MAX_TUPLES : maxo;
				nxt = (offset_q == 0) ? 1 : offset_q + 1;
				if (nxt > lim) begin
					nxt        = '0;
					ans.status = STAT_BLOCK_END;
				end
				offset_q  = nxt;
				ans.value = nxt;
			end
			REQ_TICK: begin
				if (ticks != '1)
					ticks++;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_budget = TIME_LIMIT_RST;
			blk_count   = '0;
			blk_start   = '0;
			stride_q    = '0;
			blk_last    = '0;
			visited     = '0;
			ticks       = '0;
			offset_q    = '0;
			expected_answers.delete();
			mismatches  = 0;
			awaiting    = 0;
			words_seen  = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_TIME_LIMIT)
				tick_budget = pwdata;
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0) begin
					log_mismatch("word with nothing expected", m_tdata, '0);
				end else begin
					want = expected_answers.pop_front();
					if (m_tuser != want.status)
						log_mismatch("status", 32'(m_tuser), 32'(want.status));
					if (m_tdata != want.value)
						log_mismatch("result_value", m_tdata, want.value);
				end
				words_seen++;
			end
			if (s_tvalid && s_tready) begin
				advance_sampler(s_tuser, s_tdata, got);
				expected_answers.push_back(got);
			end
			awaiting = expected_answers.size();
		end
	end

endmodule

// ===== dv/tb_coprime_stride_block_sampler.sv =====
// Testbench top for the coprime stride block sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_coprime_stride_block_sampler;
	import crs_pkg::*;

	// Timing knobs
	localparam int LIMIT_CYCLES = 3_000_000;  // watchdog, far above the slowest legal run
	localparam int DRAIN_CYCLES = 8;          // settle time once every word came back
	localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 60;
	localparam logic [PADDR_W-1:0] TIME_LIMIT_ADDR = {REG_TIME_LIMIT, 2'b00};
	localparam logic [DATA_W-1:0]  MAX_REL = 32'hFFFF_FFFE;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// [31:0] rel_blocks, [63:32] first_block_draw, [95:64] step_candidate,
	// [107:96] max_offset, [111:108] zero
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// [2:0] req_type
	logic [REQ_W-1:0]     s_tuser = REQ_TICK;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [31:0] result_value
	logic [M_TDATA_W-1:0] m_tdata;
	// [2:0] status
	logic [2:0]           m_tuser;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	int mismatches;
	int awaiting;

	// Stimulus-side bookkeeping
	logic [DATA_W-1:0] walk_count = '0;  // block count the sampler holds now
	int                items_sent = 0;
	bit                tx_tight = 1'b0;  // no sender gaps while set
	int                rx_hold_req = 0;  // receiver hold-off request, in cycles
	int                rx_left = 0;

	coprime_stride_block_sampler DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	stride_walk_checker CHK (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .awaiting(awaiting)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random ready pattern, mostly short stalls, a few long ones, and long
	// stretches with ready held high. A hold-off request from the stimulus side wins.
	initial begin : rx_side
		int r;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				m_tready    = 1'b0;
				rx_left     = rx_hold_req;
				rx_hold_req = 0;
			end else if (rx_left != 0) begin
				rx_left--;
			end else if (!m_tready) begin
				m_tready = 1'b1;
				r        = $urandom_range(0, 99);
				rx_left  = (r < 10) ? 120 : $urandom_range(0, 25);
			end else begin
				m_tready = 1'b0;
				r        = $urandom_range(0, 99);
				if (r < 85)
					rx_left = $urandom_range(0, 2);
				else if (r < 97)
					rx_left = $urandom_range(3, 12);
				else
					rx_left = $urandom_range(20, 50);
			end
		end
	end

	// Sender gap before the next word: mostly back to back or short, now and then long.
	function automatic int idle_gap();
		int r;
		if (tx_tight)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// rel_blocks for a next-block word. Shrunk sizes only when the count is small, so
	// the skip walk stays short; large counts get equal, larger or zero sizes.
	function automatic logic [DATA_W-1:0] walk_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (walk_count <= 256 && r < 40)
			return $urandom_range(0, walk_count);
		if (r < 55)
			return walk_count + $urandom_range(0, MAX_REL - walk_count);
		return walk_count;
	endfunction

	// Offer one word on the slave side and wait for its accept. tvalid stays high after
	// the accept; a drain, or a next call with a gap, lowers it at the next falling edge.
	task automatic offer_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] rel,
		input logic [DATA_W-1:0] draw, input logic [DATA_W-1:0] cand,
		input logic [OFF_W-1:0] maxo);
		int                gap;
		logic [DATA_W-1:0] s, x, y, t;
		gap = idle_gap();
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = kind;
		s_tdata  = {4'd0, maxo, cand, draw, rel};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		if (kind <= REQ_TICK)
			items_sent++;
		// follow the block count the sampler keeps, so shrunk walks stay bounded
		if (kind == REQ_SETUP && rel != 0) begin
			if (rel == 1) begin
				walk_count = rel;
			end else begin
				s = cand % rel;
				x = s;
				y = rel;
				while (x != 0) begin
					t = x;
					x = y % x;
					y = t;
				end
				if (s != 0 && y == 1)
					walk_count = rel;
			end
		end
	endtask

	task automatic do_setup(input logic [DATA_W-1:0] rel, input logic [DATA_W-1:0] cand);
		offer_request(REQ_SETUP, rel, $urandom, cand,
			OFF_W'($urandom_range(0, MAX_TUPLES_DEF)));
	endtask

	task automatic do_next();
		offer_request(REQ_NEXT, walk_size(), $urandom, $urandom,
			OFF_W'($urandom_range(0, MAX_TUPLES_DEF)));
	endtask

	task automatic do_tuple(input logic [OFF_W-1:0] maxo);
		offer_request(REQ_TUPLE, $urandom_range(0, MAX_REL), $urandom, $urandom, maxo);
	endtask

	// Begin, tick and unused codes: all data fields are don't-care noise.
	task automatic do_simple(input logic [REQ_W-1:0] kind);
		offer_request(kind, $urandom_range(0, MAX_REL), $urandom, $urandom,
			OFF_W'($urandom_range(0, MAX_TUPLES_DEF)));
	endtask

	// Lower tvalid, then wait until every expected word came back plus settle time.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_time_limit(input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = TIME_LIMIT_ADDR;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// One sampling session: a setup, then a mix of next-block walks, ticks, tuple runs,
	// scan restarts and some noise. Sometimes the walk runs past the block count.
	task automatic sampler_session();
		logic [DATA_W-1:0] rel, cand;
		logic [OFF_W-1:0]  maxo;
		int                r, steps, k;
		bit                full;
		r = $urandom_range(0, 99);
		if (r < 65)
			rel = $urandom_range(2, 48);
		else if (r < 78)
			rel = $urandom_range(0, 4);
		else
			rel = $urandom_range(257, MAX_REL);
		cand = ($urandom_range(0, 3) == 0 && rel != 0) ? $urandom_range(0, rel) : $urandom;
		do_setup(rel, cand);
		if ($urandom_range(0, 1))
			do_simple(REQ_BEGIN);
		full  = (walk_count != 0 && walk_count <= 48 && $urandom_range(0, 2) == 0);
		steps = full ? walk_count + 3 : $urandom_range(3, 16);
		for (k = 0; k < steps; k++) begin
			r = $urandom_range(0, 99);
			if (r < (full ? 85 : 62)) begin
				do_next();
			end else if (r < 76) begin
				do_simple(REQ_TICK);
			end else if (r < 88) begin
				maxo = OFF_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_TUPLES_DEF)
					: $urandom_range(0, 6));
				repeat ($urandom_range(1, 8)) do_tuple(maxo);
			end else if (r < 94) begin
				do_simple(REQ_BEGIN);
			end else begin
				// noise: any code, random fields
				case (REQ_W'($urandom_range(0, 7)))
					REQ_SETUP: do_setup($urandom_range(0, MAX_REL), $urandom);
					REQ_NEXT:  do_next();
					REQ_TUPLE: do_tuple(OFF_W'($urandom_range(0, MAX_TUPLES_DEF)));
					default:   do_simple(REQ_W'($urandom_range(0, 7)));
				endcase
			end
		end
	endtask

	initial begin : stimulus
		logic [DATA_W-1:0] budgets[PHASES];
		int                ph, k;
		budgets[0] = TIME_LIMIT_RST;
		budgets[1] = '0;
		budgets[2] = 32'd5;
		budgets[3] = 32'd12;
		budgets[4] = 32'hFFFF_FFFF;
		budgets[5] = $urandom_range(1, 60);
		budgets[6] = TIME_LIMIT_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed part, reset time budget ----
		offer_request(REQ_NEXT, 32'd5, $urandom, $urandom, '0);  // walk before any setup
		do_tuple('0);                                            // max 0: block end at once
		do_tuple(OFF_W'(MAX_TUPLES_DEF));                        // widest max
		do_simple(REQ_TICK);
		for (k = REQ_TICK + 1; k < (1 << REQ_W); k++)
			do_simple(REQ_W'(k));                                // unused codes
		do_setup('0, $urandom);                                  // empty relation
		do_setup(32'd1, $urandom);                               // count one, step forced 1
		do_setup(32'd10, 32'd4);                                 // common factor: refused
		do_setup(32'd10, 32'd30);                                // reduces to zero: refused
		offer_request(REQ_SETUP, 32'd10, 32'd27, 32'd13, '0);    // draws reduced mod count
		repeat (3) offer_request(REQ_NEXT, 32'd10, $urandom, $urandom, '0);
		offer_request(REQ_NEXT, '0, $urandom, $urandom, '0);     // empty relation mid walk
		offer_request(REQ_NEXT, 32'd5, $urandom, $urandom, '0);  // shrunk: skips
		do_simple(REQ_BEGIN);
		do_setup(32'd2, 32'd1);
		repeat (3) offer_request(REQ_NEXT, 32'd2, $urandom, $urandom, '0);  // runs past end
		offer_request(REQ_SETUP, MAX_REL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
		offer_request(REQ_NEXT, MAX_REL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
		repeat (3) do_tuple(12'd2);                              // 1, 2, block end

		// zero budget: the first block of a scan is already out of time
		wait_drained();
		write_time_limit('0);
		do_simple(REQ_BEGIN);
		do_next();
		// tiny budget: ticks during the walk run it out
		wait_drained();
		write_time_limit(32'd2);
		do_simple(REQ_BEGIN);
		offer_request(REQ_NEXT, MAX_REL, $urandom, $urandom, '0);
		repeat (2) do_simple(REQ_TICK);
		offer_request(REQ_NEXT, MAX_REL, $urandom, $urandom, '0);

		// ---- random phases, one time budget each ----
		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_time_limit(budgets[ph]);
			if (ph == 2) begin
				// receiver holds off while the sender keeps pushing: block fills and stalls
				@(posedge clk);
				rx_hold_req = HOLD_CYCLES;
				tx_tight    = 1'b1;
				repeat (4) do_simple(REQ_TICK);
				repeat (4) do_next();
				tx_tight    = 1'b0;
			end
			while (items_sent < 30 + PHASE_ITEMS * (ph + 1)) begin
				// every so often a back-to-back burst with no sender gaps
				tx_tight = ($urandom_range(0, 5) == 0);
				sampler_session();
				tx_tight = 1'b0;
			end
		end

		wait_drained();
		if (mismatches == 0 && awaiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== coprime_stride_block_sampler.f =====
hdl/crs_pkg.sv
hdl/crs_rem.sv
hdl/coprime_stride_block_sampler.sv
hdl/crs_chk.sv
dv/stride_walk_checker.sv
dv/tb_coprime_stride_block_sampler.sv
